// File: rtl/hpse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpse_pkg
// shared types and constants of the hevc parameter set extractor
// ----------------------------------------------------------------------------
package hpse_pkg;

  // default capture memory depth in bytes
  localparam int CAPTURE_BYTES_DEF = 512;

  // fixed field widths
  localparam int ADDR_W    = 9;
  localparam int OFF_W     = 9;
  localparam int LEN_OUT_W = 10;

  // nal unit types of interest
  localparam logic [5:0] TYPE_VPS = 6'd32;
  localparam logic [5:0] TYPE_SPS = 6'd33;
  localparam logic [5:0] TYPE_PPS = 6'd34;

  // input command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // result kinds
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // summary status codes
  localparam logic [1:0] STAT_COMPLETE   = 2'd0;
  localparam logic [1:0] STAT_INCOMPLETE = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW   = 2'd2;

  typedef enum logic [1:0] {
    PH_SEEK    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2,
    PH_OVER    = 2'd3
  } phase_t;

  typedef struct packed {
    logic              command;
    logic [7:0]        data_byte;
    logic              last;
    logic [ADDR_W-1:0] read_address;
  } in_t;

  typedef struct packed {
    logic                 kind;
    logic [1:0]           status;
    logic [OFF_W-1:0]     vps_offset;
    logic [LEN_OUT_W-1:0] vps_length;
    logic [OFF_W-1:0]     sps_offset;
    logic [LEN_OUT_W-1:0] sps_length;
    logic [OFF_W-1:0]     pps_offset;
    logic [LEN_OUT_W-1:0] pps_length;
    logic [7:0]           read_data;
  } out_t;

  function automatic logic is_param_set(input logic [5:0] t);
    is_param_set = (t == TYPE_VPS) || (t == TYPE_SPS) || (t == TYPE_PPS);
  endfunction

endpackage

// File: rtl/hevc_param_set_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path: a summary or read beat passes stage one, then the output register, to out_valid
// throughput: one input beat per cycle while in_stall is low; pushes, reads and summaries all sustain it,
//   set by the single-port capture memory taking one write or one read per beat
// reset: parse state, fill offset and set table clear at once; capture memory
//   contents are not cleared and read undefined until written
// ----------------------------------------------------------------------------
// hevc_param_set_extractor
// splits an annex-b access unit into nal units and keeps the first vps, sps
// and pps in a capture memory; reports their place on the last byte
// ----------------------------------------------------------------------------
module hevc_param_set_extractor #(
  parameter int CAPTURE_BYTES = hpse_pkg::CAPTURE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hpse_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hpse_pkg::out_t out_data
);
  import hpse_pkg::*;

  // memory index, unit byte count (saturates at depth + 4), fill offset
  localparam int AW      = $clog2(CAPTURE_BYTES);
  localparam int CW      = $clog2(CAPTURE_BYTES + 5);
  localparam int FW      = $clog2(CAPTURE_BYTES + 1);
  localparam int LW      = FW;
  localparam int RW      = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
  localparam int CNT_CAP = CAPTURE_BYTES + 4;

  typedef struct packed {
    phase_t               ph;
    logic [1:0]           zrun;
    logic [5:0]           utype;
    logic [CW-1:0]        ucnt;
    logic                 capt;
    logic [FW-1:0]        fill;
    logic [2:0][OFF_W-1:0] offs;
    logic [2:0][LW-1:0]   lens;
  } pstate_t;

  localparam pstate_t PST_CLEAR = '{ph: PH_SEEK, default: '0};

  // start a new nal unit after a start code
  function automatic pstate_t open_unit(input pstate_t s);
    pstate_t r;
    r      = s;
    r.ph   = PH_PAYLOAD;
    r.zrun = '0;
    r.ucnt = '0;
    r.capt = 1'b0;
    return r;
  endfunction

  // end the open unit; keep it if it is a wanted set that fits
  function automatic pstate_t close_unit(input pstate_t s, input logic [CW-1:0] len);
    pstate_t     r;
    logic [1:0]  k;
    logic [CW:0] sum;
    r   = s;
    k   = s.utype[1:0];
    sum = (CW+1)'(s.fill) + (CW+1)'(len);
    if (s.capt && (len >= CW'(2)) && is_param_set(s.utype)) begin
      if (sum > (CW+1)'(CAPTURE_BYTES)) begin
        r.ph = PH_OVER;
      end else begin
        r.offs[k] = OFF_W'(s.fill);
        r.lens[k] = LW'(len);
        r.fill    = FW'(sum);
        if ((r.lens[0] != '0) && (r.lens[1] != '0) && (r.lens[2] != '0)) begin
          r.ph = PH_DONE;
        end else begin
          r = open_unit(r);
        end
      end
    end else begin
      r = open_unit(r);
    end
    return r;
  endfunction

  // handshake and stage signals
  logic    in_acc;
  logic    push_acc;
  logic    rd_acc;
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  out_t    s1_data_r;
  out_t    s1_data_nxt;
  logic    s1_rd_r;
  logic    s1_rng_r;
  logic    s1_move;
  logic    out_valid_r;
  out_t    out_data_r;
  out_t    out_data_nxt;

  // parse state
  pstate_t pst_r;
  pstate_t pst_nxt;
  pstate_t pst_w;
  logic [CW:0] wsum;

  // capture memory
  logic [7:0]    cap_mem [CAPTURE_BYTES];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] rd_ext;
  logic          rd_rng;
  logic [AW-1:0] rd_idx;
  logic [7:0]    rdq_r;

  // stage one drains into the output register when that is free or taken
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign push_acc = in_acc && (in_data.command == CMD_PUSH);
  assign rd_acc   = in_acc && (in_data.command == CMD_READ);

  assign rd_ext = RW'(in_data.read_address);
  assign rd_rng = rd_ext < RW'(CAPTURE_BYTES);
  assign rd_idx = rd_rng ? rd_ext[AW-1:0] : '0;

  // byte parser: start code search, unit bookkeeping, speculative capture write
  always_comb begin
    pst_w       = pst_r;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wsum        = '0;
    s1_data_nxt = '0;
    if (rd_acc) begin
      s1_data_nxt.kind = KIND_READ;
    end
    if (push_acc) begin
      if ((pst_w.ph == PH_SEEK) || (pst_w.ph == PH_PAYLOAD)) begin
        if ((in_data.data_byte == 8'd1) && (pst_w.zrun >= 2'd2)) begin
          // start code: up to three trailing zeros of the run belong to it
          if (pst_w.ph == PH_PAYLOAD) begin
            pst_w = close_unit(pst_w, pst_w.ucnt - CW'(pst_w.zrun));
          end else begin
            pst_w = open_unit(pst_w);
          end
        end else begin
          if (pst_w.ph == PH_PAYLOAD) begin
            if (pst_w.ucnt == '0) begin
              // nal header byte sets the type and whether to keep the unit
              pst_w.utype = in_data.data_byte[6:1];
              pst_w.capt  = is_param_set(in_data.data_byte[6:1]) &&
                            (pst_w.lens[in_data.data_byte[2:1]] == '0);
            end
            // zeros go in too; a start code later cuts them off by length
            wsum = (CW+1)'(pst_w.fill) + (CW+1)'(pst_w.ucnt);
            if (pst_w.capt && (wsum < (CW+1)'(CAPTURE_BYTES))) begin
              wr_en   = 1'b1;
              wr_addr = wsum[AW-1:0];
            end
            if (pst_w.ucnt < CW'(CNT_CAP)) begin
              pst_w.ucnt = pst_w.ucnt + CW'(1);
            end
          end
          if (in_data.data_byte == 8'd0) begin
            pst_w.zrun = (pst_w.zrun < 2'd3) ? pst_w.zrun + 2'd1 : 2'd3;
          end else begin
            pst_w.zrun = '0;
          end
        end
      end
      if (in_data.last) begin
        // end of access unit: close what is open, report, rearm
        if (pst_w.ph == PH_PAYLOAD) begin
          pst_w = close_unit(pst_w, pst_w.ucnt);
        end
        s1_data_nxt.kind = KIND_SUMMARY;
        unique case (pst_w.ph)
          PH_DONE: s1_data_nxt.status = STAT_COMPLETE;
          PH_OVER: s1_data_nxt.status = STAT_OVERFLOW;
          default: s1_data_nxt.status = STAT_INCOMPLETE;
        endcase
        s1_data_nxt.vps_offset = pst_w.offs[0];
        s1_data_nxt.vps_length = LEN_OUT_W'(pst_w.lens[0]);
        s1_data_nxt.sps_offset = pst_w.offs[1];
        s1_data_nxt.sps_length = LEN_OUT_W'(pst_w.lens[1]);
        s1_data_nxt.pps_offset = pst_w.offs[2];
        s1_data_nxt.pps_length = LEN_OUT_W'(pst_w.lens[2]);
        pst_w = PST_CLEAR;
      end
    end
    pst_nxt      = pst_w;
    s1_valid_nxt = (in_acc && ((in_data.command == CMD_READ) || in_data.last)) ||
                   (s1_valid_r && !s1_move);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pst_r <= PST_CLEAR;
    end else begin
      pst_r <= pst_nxt;
    end
  end

  // capture memory: at most one write per push beat or one read per read beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cap_mem[wr_addr] <= in_data.data_byte;
    end
    if (rd_acc) begin
      rdq_r <= cap_mem[rd_idx];
    end
  end

  // stage one holds the result while the memory read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= s1_data_nxt;
      s1_rd_r   <= (in_data.command == CMD_READ);
      s1_rng_r  <= rd_rng;
    end
  end

  // read data joins the stage one beat on its way out
  always_comb begin
    out_data_nxt           = s1_data_r;
    out_data_nxt.read_data = (s1_rd_r && s1_rng_r) ? rdq_r : 8'd0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/hevc_param_set_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevc_param_set_extractor_tb
// feeds annex-b access units byte by byte, with capture reads mixed in, and
// checks every summary and read beat against an in-bench parser that tracks
// start codes, nal types, the set table and the capture memory contents
// ----------------------------------------------------------------------------
module hevc_param_set_extractor_tb;
  import hpse_pkg::*;

  localparam int CAP         = CAPTURE_BYTES_DEF;
  localparam int UNIT_CAP    = CAP + 4;      // unit byte counter saturates here
  localparam int STALL_LIMIT = 4000;         // cycles without any accepted beat
  localparam int HOLD_CYCLES = 300;          // long receiver hold-off
  localparam int TAIL_CYCLES = 8;            // slack after the last result before the final report
  localparam int PHASE_BEATS = 320;
  localparam logic [5:0] TYPE_SLICE = 6'd1;  // an ordinary coded slice

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #5 clk = ~clk;

  hevc_param_set_extractor #(
    .CAPTURE_BYTES(CAP)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // parser state mirrored in the bench
  // --------------------------------------------------------------------------
  phase_t     ps_phase;
  logic [1:0] ps_zero_run;      // zeros seen in a row, capped at three
  logic [5:0] ps_unit_type;
  logic [9:0] ps_unit_len;      // bytes of the open unit so far
  logic       ps_capturing;     // open unit is a wanted set not yet held
  logic [9:0] ps_fill;          // next free capture address
  logic [8:0] ps_set_off [3];
  logic [9:0] ps_set_len [3];
  logic [7:0] cap_mem [CAP];
  bit         cap_written [CAP];
  int         written_addrs [$];  // every capture address written so far
  out_t       expected_q [$];     // summary and read beats still to come

  task automatic clear_parse();
    ps_phase     = PH_SEEK;
    ps_zero_run  = '0;
    ps_unit_type = '0;
    ps_unit_len  = '0;
    ps_capturing = 1'b0;
    ps_fill      = '0;
    for (int k = 0; k < 3; k++) begin
      ps_set_off[k] = '0;
      ps_set_len[k] = '0;
    end
  endtask

  task automatic unit_open();
    ps_phase     = PH_PAYLOAD;
    ps_zero_run  = '0;
    ps_unit_len  = '0;
    ps_capturing = 1'b0;
  endtask

  // a unit ends: keep it if it is a wanted set that fits, else move on
  task automatic unit_close(input int len);
    int k;
    if (ps_capturing && len >= 2 && ps_unit_type >= TYPE_VPS && ps_unit_type <= TYPE_PPS) begin
      k = int'(ps_unit_type - TYPE_VPS);
      if (int'(ps_fill) + len > CAP) begin
        ps_phase = PH_OVER;
        return;
      end
      ps_set_off[k] = 9'(ps_fill);
      ps_set_len[k] = 10'(len);
      ps_fill       = ps_fill + 10'(len);
      if (ps_set_len[0] != 0 && ps_set_len[1] != 0 && ps_set_len[2] != 0) begin
        ps_phase = PH_DONE;
        return;
      end
    end
    unit_open();
  endtask

  task automatic stream_byte(input logic [7:0] b);
    int a;
    // once all sets are held or memory ran out, the rest of the access unit is ignored
    if (ps_phase == PH_DONE || ps_phase == PH_OVER) return;
    // start code: two or more zeros then 01; up to three of those zeros leave the payload
    if (b == 8'h01 && ps_zero_run >= 2) begin
      if (ps_phase == PH_PAYLOAD) unit_close(int'(ps_unit_len) - int'(ps_zero_run));
      else unit_open();
      return;
    end
    if (ps_phase == PH_PAYLOAD) begin
      if (ps_unit_len == 0) begin
        ps_unit_type = b[6:1];
        ps_capturing = 1'b0;
        if (b[6:1] >= TYPE_VPS && b[6:1] <= TYPE_PPS) begin
          ps_capturing = (ps_set_len[b[6:1] - TYPE_VPS] == 0);
        end
      end
      // bytes go to memory as they arrive, past the end they are dropped
      a = int'(ps_fill) + int'(ps_unit_len);
      if (ps_capturing && a < CAP) begin
        cap_mem[a] = b;
        if (!cap_written[a]) begin
          cap_written[a] = 1'b1;
          written_addrs.push_back(a);
        end
      end
      if (ps_unit_len < UNIT_CAP) ps_unit_len++;
    end
    if (b == 8'h00) ps_zero_run = (ps_zero_run < 2'd3) ? ps_zero_run + 2'd1 : 2'd3;
    else ps_zero_run = '0;
  endtask

  // works out the beat, if any, that one accepted input beat causes
  task automatic predict_beat(input in_t beat);
    out_t r;
    r = '0;
    if (beat.command == CMD_READ) begin
      r.kind = KIND_READ;
      if (int'(beat.read_address) < CAP) r.read_data = cap_mem[beat.read_address];
      expected_q.push_back(r);
    end else begin
      stream_byte(beat.data_byte);
      if (beat.last) begin
        // the open unit ends here with its trailing zeros kept
        if (ps_phase == PH_PAYLOAD) unit_close(int'(ps_unit_len));
        r.kind = KIND_SUMMARY;
        case (ps_phase)
          PH_DONE: r.status = STAT_COMPLETE;
          PH_OVER: r.status = STAT_OVERFLOW;
          default: r.status = STAT_INCOMPLETE;
        endcase
        r.vps_offset = ps_set_off[0];
        r.vps_length = ps_set_len[0];
        r.sps_offset = ps_set_off[1];
        r.sps_length = ps_set_len[1];
        r.pps_offset = ps_set_off[2];
        r.pps_length = ps_set_len[2];
        expected_q.push_back(r);
        clear_parse();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  int error_count = 0;

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 40) $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // stimulus queue and driver
  // --------------------------------------------------------------------------
  in_t        stim_q [$];
  logic [7:0] au_bytes [$];
  int         beats_queued   = 0;
  int         beats_in       = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  bit         hold_kick      = 1'b0;  // toggled to ask for a long hold-off

  // a new beat is offered only once the current one has gone through
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= stim_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off counted here on request
  int hold_left = 0;
  bit hold_seen = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on input beats, compare on result beats, watchdog
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_beat(in_data);
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_error("result beat with nothing expected");
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 16'(out_data.kind), 16'(want.kind));
          check_field("status", 16'(out_data.status), 16'(want.status));
          check_field("vps_offset", 16'(out_data.vps_offset), 16'(want.vps_offset));
          check_field("vps_length", 16'(out_data.vps_length), 16'(want.vps_length));
          check_field("sps_offset", 16'(out_data.sps_offset), 16'(want.sps_offset));
          check_field("sps_length", 16'(out_data.sps_length), 16'(want.sps_length));
          check_field("pps_offset", 16'(out_data.pps_offset), 16'(want.pps_offset));
          check_field("pps_length", 16'(out_data.pps_length), 16'(want.pps_length));
          check_field("read_data", 16'(out_data.read_data), 16'(want.read_data));
        end
      end
      // only count while work is outstanding
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else if (stim_q.size() != 0 || in_valid || expected_q.size() != 0) begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t timeout: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus building
  // --------------------------------------------------------------------------
  task automatic queue_beat(input in_t beat);
    stim_q.push_back(beat);
    beats_queued++;
  endtask

  // unused fields of a read carry random values
  task automatic queue_read(input int addr);
    in_t beat;
    beat.command      = CMD_READ;
    beat.data_byte    = 8'($urandom);
    beat.last         = 1'($urandom);
    beat.read_address = 9'(addr);
    queue_beat(beat);
  endtask

  // reads only go to addresses already written at least once
  task automatic queue_random_read();
    if (written_addrs.size() != 0)
      queue_read(written_addrs[$urandom_range(written_addrs.size() - 1)]);
  endtask

  task automatic add_start(input int zeros);
    repeat (zeros) au_bytes.push_back(8'h00);
    au_bytes.push_back(8'h01);
  endtask

  // header byte carries the type in bits 6..1, the other two bits random
  task automatic add_unit(input logic [5:0] ty, input int len);
    au_bytes.push_back({1'($urandom), ty, 1'($urandom)});
    for (int i = 1; i < len; i++)
      au_bytes.push_back(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
  endtask

  // sends the built access unit, last flag on its final byte
  task automatic flush_au(input int read_pct);
    in_t beat;
    foreach (au_bytes[i]) begin
      if ($urandom_range(99) < read_pct) queue_random_read();
      beat.command      = CMD_PUSH;
      beat.data_byte    = au_bytes[i];
      beat.last         = (i == au_bytes.size() - 1);
      beat.read_address = 9'($urandom);
      queue_beat(beat);
    end
    au_bytes.delete();
  endtask

  task automatic build_random_au();
    int         shape;
    int         zeros;
    int         len;
    logic [5:0] ty;
    shape = $urandom_range(99);
    // noise: random bytes that likely hold no start code
    if (shape < 6) begin
      repeat ($urandom_range(1, 8)) au_bytes.push_back(8'($urandom));
      return;
    end
    // junk ahead of the first start code
    if (shape < 20) repeat ($urandom_range(1, 4)) au_bytes.push_back(8'($urandom));
    repeat ($urandom_range(1, 5)) begin
      // a broken start code now and then, it mostly stays as payload
      if ($urandom_range(15) == 0) begin
        au_bytes.push_back(8'h00);
        au_bytes.push_back(8'h01);
      end
      zeros = $urandom_range(9);
      zeros = (zeros < 7) ? 2 : (zeros < 9) ? 3 : $urandom_range(4, 6);
      add_start(zeros);
      ty  = ($urandom_range(3) != 0) ? TYPE_VPS + 6'($urandom_range(2)) : 6'($urandom);
      // mostly short units, a few long enough to run out of memory
      len = ($urandom_range(29) == 0) ? $urandom_range(200, 560) : $urandom_range(1, 12);
      add_unit(ty, len);
    end
    // trailing zeros or a cut-off start code at the end
    if (shape >= 90) repeat ($urandom_range(1, 3)) au_bytes.push_back(8'h00);
  endtask

  task automatic drain();
    while (beats_in != beats_queued || expected_q.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_end;
    clear_parse();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed access unit: junk byte, four-byte start code, a vps, a slice that
    // is not kept, a header-only pps that is too short, then sps and pps
    au_bytes.push_back(8'hFF);
    add_start(3);
    add_unit(TYPE_VPS, 3);
    add_start(2);
    add_unit(TYPE_SLICE, 2);
    add_start(2);
    add_unit(TYPE_PPS, 1);
    add_start(2);
    add_unit(TYPE_SPS, 2);
    add_start(2);
    add_unit(TYPE_PPS, 2);
    flush_au(0);
    // single zero byte with last: nothing found
    au_bytes.push_back(8'h00);
    flush_au(0);
    drain();
    queue_read(0);
    queue_read(written_addrs[written_addrs.size() - 1]);
    drain();

    // vps longer than memory: fills every address, counter saturates, overflow
    add_start(2);
    add_unit(TYPE_VPS, 600);
    flush_au(0);
    drain();
    // a stray start code inside the payload can cut the unit short
    if (cap_written[CAP - 1]) queue_read(CAP - 1);
    queue_read(0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      phase_end = beats_queued + PHASE_BEATS;
      if (ph == 0) begin
        // receiver holds off while reads keep coming, so the block backs up
        hold_kick = ~hold_kick;
        repeat (60) queue_random_read();
      end
      while (beats_queued < phase_end) begin
        while (stim_q.size() > 32) @(negedge clk);
        build_random_au();
        flush_au(6);
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 6)) queue_random_read();
      end
      // sender waits here until every result of the phase is back
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/hpse_pkg.sv
rtl/hevc_param_set_extractor.sv
tb/hevc_param_set_extractor_tb.sv
